/* hw/rtl/mhc_pkg.sv */
`timescale 1ns / 1ps
package mhc_pkg;

  localparam int IN_W      = 20;
  localparam int OUT_FRAC  = 16;
  localparam int OUT_W     = OUT_FRAC + 1;
  localparam int X_W       = 29;                 // x in q24, below 32
  localparam int DEN_SHIFT = 6;                  // temperature scaled to line up with x
  localparam int DEN_W     = IN_W + DEN_SHIFT;
  localparam int NUM_W     = 53;                 // frequency times kx
  localparam int CMP_W     = DEN_W + X_W;
  localparam int R_SHIFT   = 31;                 // x q24 to r q62 with the 2^-7 prescale
  localparam int R_W       = X_W + R_SHIFT;
  localparam int V_W       = 58;
  localparam int TERMS     = 16;
  localparam int SQUARINGS = 7;
  localparam int Q_W       = 40;
  localparam int Q2_W      = 48;
  localparam int RND_SHIFT = 94 - OUT_FRAC;
  localparam int RES_W     = 112 - RND_SHIFT;

  localparam logic [32:0]      KX_Q32  = 33'd6179492259;
  localparam logic [63:0]      ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0]      TWO_Q62 = 64'h8000_0000_0000_0000;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << OUT_FRAC;

  typedef enum logic [1:0] {
    SEL_CALC,
    SEL_ZERO,
    SEL_ONE
  } res_sel_t;

  typedef struct packed {
    logic           vld;
    res_sel_t       sel;
    logic [X_W-1:0] x;
  } item_t;

  // floor(2^64 / n)
  function automatic logic [63:0] recip(input int n);
    logic [63:0] m;
    case (n)
      2:       m = 64'h8000_0000_0000_0000;
      3:       m = 64'h5555_5555_5555_5555;
      4:       m = 64'h4000_0000_0000_0000;
      5:       m = 64'h3333_3333_3333_3333;
      6:       m = 64'h2AAA_AAAA_AAAA_AAAA;
      7:       m = 64'h2492_4924_9249_2492;
      8:       m = 64'h2000_0000_0000_0000;
      9:       m = 64'h1C71_C71C_71C7_1C71;
      10:      m = 64'h1999_9999_9999_9999;
      11:      m = 64'h1745_D174_5D17_45D1;
      12:      m = 64'h1555_5555_5555_5555;
      13:      m = 64'h13B1_3B13_B13B_13B1;
      14:      m = 64'h1249_2492_4924_9249;
      15:      m = 64'h1111_1111_1111_1111;
      16:      m = 64'h1000_0000_0000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/mhc_expo.sv */
`timescale 1ns / 1ps
module mhc_expo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mhc_pkg::item_t      in_item,
  output mhc_pkg::item_t      out_item,
  output logic [63:0]         e_out,
  output logic [63:0]         d_out
);

  mhc_pkg::item_t                tk_item_r [0:mhc_pkg::TERMS-1];
  logic [mhc_pkg::R_W-1:0]       tk_t_r    [0:mhc_pkg::TERMS-1];
  logic [mhc_pkg::R_W-1:0]       tk_d_r    [0:mhc_pkg::TERMS-1];

  mhc_pkg::item_t                sq_item_r [0:mhc_pkg::SQUARINGS];
  logic [63:0]                   sq_e_r    [0:mhc_pkg::SQUARINGS];
  logic [63:0]                   sq_d_r    [0:mhc_pkg::SQUARINGS];

  // series start: t = d = r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tk_item_r[0].vld <= 1'b0;
    end else if (en) begin
      tk_item_r[0] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tk_t_r[0] <= {in_item.x, {mhc_pkg::R_SHIFT{1'b0}}};
      tk_d_r[0] <= {in_item.x, {mhc_pkg::R_SHIFT{1'b0}}};
    end
  end

  // one series term per five stages: t*r, shift, reciprocal partials, sum, correction
  for (genvar j = 0; j < mhc_pkg::TERMS - 1; j++) begin : g_term
    localparam logic [4:0]  N = 5'(j + 2);
    localparam logic [63:0] M = mhc_pkg::recip(j + 2);

    mhc_pkg::item_t          s1_item_r, s2_item_r, s3_item_r, s4_item_r;
    logic [mhc_pkg::R_W-1:0] s1_d_r, s2_d_r, s3_d_r, s4_d_r;
    logic [58:0]             s1_plo_r, s1_phi_r;
    logic [mhc_pkg::V_W-1:0] s2_v_r, s3_v_r, s4_v_r, s4_q_r;
    logic [60:0]             s3_ll_r, s3_lh_r, s3_hl_r, s3_hh_r;
    logic [88:0]             psum_nxt;
    logic [121:0]            qsum_nxt;
    logic [mhc_pkg::V_W-1:0] qn_nxt, rem_nxt;
    logic [mhc_pkg::R_W-1:0] tn_nxt, dn_nxt;

    always_comb begin
      psum_nxt = (89'(s1_phi_r) << 30) + 89'(s1_plo_r);
      qsum_nxt = (122'(s3_hh_r) << 61) + (122'(s3_hl_r) << 29)
               + (122'(s3_lh_r) << 32) + 122'(s3_ll_r);
      qn_nxt   = mhc_pkg::V_W'(s4_q_r * mhc_pkg::V_W'(N));
      rem_nxt  = s4_v_r - qn_nxt;
      tn_nxt   = mhc_pkg::R_W'(s4_q_r) + mhc_pkg::R_W'(rem_nxt >= mhc_pkg::V_W'(N));
      if (N[0]) begin
        dn_nxt = s4_d_r + tn_nxt;
      end else begin
        dn_nxt = s4_d_r - tn_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_item_r.vld      <= 1'b0;
        s2_item_r.vld      <= 1'b0;
        s3_item_r.vld      <= 1'b0;
        s4_item_r.vld      <= 1'b0;
        tk_item_r[j+1].vld <= 1'b0;
      end else if (en) begin
        s1_item_r      <= tk_item_r[j];
        s2_item_r      <= s1_item_r;
        s3_item_r      <= s2_item_r;
        s4_item_r      <= s3_item_r;
        tk_item_r[j+1] <= s4_item_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_plo_r    <= 59'(tk_t_r[j][29:0]) * 59'(tk_item_r[j].x);
        s1_phi_r    <= 59'(tk_t_r[j][59:30]) * 59'(tk_item_r[j].x);
        s1_d_r      <= tk_d_r[j];
        s2_v_r      <= psum_nxt[88:31];
        s2_d_r      <= s1_d_r;
        s3_ll_r     <= 61'(s2_v_r[28:0]) * 61'(M[31:0]);
        s3_lh_r     <= 61'(s2_v_r[28:0]) * 61'(M[63:32]);
        s3_hl_r     <= 61'(s2_v_r[57:29]) * 61'(M[31:0]);
        s3_hh_r     <= 61'(s2_v_r[57:29]) * 61'(M[63:32]);
        s3_v_r      <= s2_v_r;
        s3_d_r      <= s2_d_r;
        s4_q_r      <= qsum_nxt[121:64];
        s4_v_r      <= s3_v_r;
        s4_d_r      <= s3_d_r;
        tk_t_r[j+1] <= tn_nxt;
        tk_d_r[j+1] <= dn_nxt;
      end
    end
  end

  // e = 1 - d, then repeated squaring of e, with d updated as d * (2 - d)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_item_r[0].vld <= 1'b0;
    end else if (en) begin
      sq_item_r[0] <= tk_item_r[mhc_pkg::TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_e_r[0] <= mhc_pkg::ONE_Q62 - 64'(tk_d_r[mhc_pkg::TERMS-1]);
      sq_d_r[0] <= 64'(tk_d_r[mhc_pkg::TERMS-1]);
    end
  end

  for (genvar k = 0; k < mhc_pkg::SQUARINGS; k++) begin : g_square
    mhc_pkg::item_t s1_item_r;
    logic [63:0]    m_nxt;
    logic [63:0]    s1_ell_r, s1_elh_r, s1_ehh_r;
    logic [63:0]    s1_dll_r, s1_dlh_r, s1_dhl_r, s1_dhh_r;
    logic [127:0]   esum_nxt, dsum_nxt;

    always_comb begin
      m_nxt    = mhc_pkg::TWO_Q62 - sq_d_r[k];
      esum_nxt = (128'(s1_ehh_r) << 64) + (128'(s1_elh_r) << 33) + 128'(s1_ell_r);
      dsum_nxt = (128'(s1_dhh_r) << 64) + (128'(s1_dlh_r) << 32)
               + (128'(s1_dhl_r) << 32) + 128'(s1_dll_r);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_item_r.vld      <= 1'b0;
        sq_item_r[k+1].vld <= 1'b0;
      end else if (en) begin
        s1_item_r      <= sq_item_r[k];
        sq_item_r[k+1] <= s1_item_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_ell_r    <= 64'(sq_e_r[k][31:0]) * 64'(sq_e_r[k][31:0]);
        s1_elh_r    <= 64'(sq_e_r[k][31:0]) * 64'(sq_e_r[k][63:32]);
        s1_ehh_r    <= 64'(sq_e_r[k][63:32]) * 64'(sq_e_r[k][63:32]);
        s1_dll_r    <= 64'(sq_d_r[k][31:0]) * 64'(m_nxt[31:0]);
        s1_dlh_r    <= 64'(sq_d_r[k][31:0]) * 64'(m_nxt[63:32]);
        s1_dhl_r    <= 64'(sq_d_r[k][63:32]) * 64'(m_nxt[31:0]);
        s1_dhh_r    <= 64'(sq_d_r[k][63:32]) * 64'(m_nxt[63:32]);
        sq_e_r[k+1] <= esum_nxt[125:62];
        sq_d_r[k+1] <= dsum_nxt[125:62];
      end
    end
  end

  assign out_item = sq_item_r[mhc_pkg::SQUARINGS];
  assign e_out    = sq_e_r[mhc_pkg::SQUARINGS];
  assign d_out    = sq_d_r[mhc_pkg::SQUARINGS];

endmodule

/* hw/rtl/mhc_qdiv.sv */
`timescale 1ns / 1ps
module mhc_qdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  mhc_pkg::item_t            in_item,
  input  logic [63:0]               in_e,
  input  logic [63:0]               in_d,
  output logic                      out_valid,
  output logic [mhc_pkg::OUT_W-1:0] out_capacity_ratio
);

  mhc_pkg::item_t          qd_item_r [0:mhc_pkg::Q_W];
  logic [63:0]             qd_rem_r  [0:mhc_pkg::Q_W];
  logic [mhc_pkg::Q_W-1:0] qd_q_r    [0:mhc_pkg::Q_W];
  logic [63:0]             qd_d_r    [0:mhc_pkg::Q_W];
  logic [63:0]             qd_e_r    [0:mhc_pkg::Q_W];

  mhc_pkg::item_t           m1_item_r, m2_item_r, m3_item_r;
  logic [39:0]              m1_hh_r, m1_hl_r, m1_ll_r;
  logic [63:0]              m1_e_r, m2_e_r;
  logic [mhc_pkg::Q2_W-1:0] m2_q2_r;
  logic [55:0]              m3_hh_r, m3_hl_r, m3_lh_r, m3_ll_r;
  logic [79:0]              sq_nxt;
  logic [111:0]             fsum_nxt;
  logic [mhc_pkg::RES_W-1:0] res_nxt;
  logic [mhc_pkg::OUT_W-1:0] ratio_nxt;
  logic                      out_valid_r;
  logic [mhc_pkg::OUT_W-1:0] out_ratio_r;

  // the first 30 quotient positions are known zero, so start from x * 2^30
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_item_r[0].vld <= 1'b0;
    end else if (en) begin
      qd_item_r[0] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_rem_r[0] <= 64'({in_item.x, 30'b0});
      qd_q_r[0]   <= '0;
      qd_d_r[0]   <= in_d;
      qd_e_r[0]   <= in_e;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < mhc_pkg::Q_W; k++) begin : g_div
    logic [64:0] rem2_nxt, diff_nxt;
    logic        ge_nxt;

    always_comb begin
      rem2_nxt = {qd_rem_r[k], 1'b0};
      ge_nxt   = rem2_nxt >= {1'b0, qd_d_r[k]};
      diff_nxt = rem2_nxt - {1'b0, qd_d_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_item_r[k+1].vld <= 1'b0;
      end else if (en) begin
        qd_item_r[k+1] <= qd_item_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd_rem_r[k+1] <= ge_nxt ? diff_nxt[63:0] : rem2_nxt[63:0];
        qd_q_r[k+1]   <= {qd_q_r[k][mhc_pkg::Q_W-2:0], ge_nxt};
        qd_d_r[k+1]   <= qd_d_r[k];
        qd_e_r[k+1]   <= qd_e_r[k];
      end
    end
  end

  always_comb begin
    sq_nxt   = (80'(m1_hh_r) << 40) + (80'(m1_hl_r) << 21) + 80'(m1_ll_r);
    fsum_nxt = (112'(m3_hh_r) << 56) + (112'(m3_hl_r) << 24) + (112'(m3_lh_r) << 32)
             + 112'(m3_ll_r) + (112'(1) << (mhc_pkg::RND_SHIFT - 1));
    res_nxt  = fsum_nxt[111:mhc_pkg::RND_SHIFT];
    case (m3_item_r.sel)
      mhc_pkg::SEL_CALC: begin
        if (res_nxt > mhc_pkg::RES_W'(mhc_pkg::OUT_ONE)) begin
          ratio_nxt = mhc_pkg::OUT_ONE;
        end else begin
          ratio_nxt = res_nxt[mhc_pkg::OUT_W-1:0];
        end
      end
      mhc_pkg::SEL_ZERO: ratio_nxt = '0;
      mhc_pkg::SEL_ONE:  ratio_nxt = mhc_pkg::OUT_ONE;
      default:           ratio_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_item_r.vld <= 1'b0;
      m2_item_r.vld <= 1'b0;
      m3_item_r.vld <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      m1_item_r   <= qd_item_r[mhc_pkg::Q_W];
      m2_item_r   <= m1_item_r;
      m3_item_r   <= m2_item_r;
      out_valid_r <= m3_item_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_hh_r     <= 40'(qd_q_r[mhc_pkg::Q_W][39:20]) * 40'(qd_q_r[mhc_pkg::Q_W][39:20]);
      m1_hl_r     <= 40'(qd_q_r[mhc_pkg::Q_W][39:20]) * 40'(qd_q_r[mhc_pkg::Q_W][19:0]);
      m1_ll_r     <= 40'(qd_q_r[mhc_pkg::Q_W][19:0]) * 40'(qd_q_r[mhc_pkg::Q_W][19:0]);
      m1_e_r      <= qd_e_r[mhc_pkg::Q_W];
      m2_q2_r     <= sq_nxt[79:32];
      m2_e_r      <= m1_e_r;
      m3_hh_r     <= 56'(m2_q2_r[47:24]) * 56'(m2_e_r[63:32]);
      m3_hl_r     <= 56'(m2_q2_r[47:24]) * 56'(m2_e_r[31:0]);
      m3_lh_r     <= 56'(m2_q2_r[23:0]) * 56'(m2_e_r[63:32]);
      m3_ll_r     <= 56'(m2_q2_r[23:0]) * 56'(m2_e_r[31:0]);
      out_ratio_r <= ratio_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_capacity_ratio = out_ratio_r;

endmodule

/* hw/rtl/mode_heat_capacity.sv */
`timescale 1ns / 1ps
// throughput: one item per cycle; the whole pipeline holds while a result waits
// stages: x division 31, series and squarings 91, x/d division and products 45
// reset: synchronous active-low rst_n clears every stage valid bit and the output valid
module mode_heat_capacity (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mhc_pkg::IN_W-1:0]  in_temperature,
  input  logic [mhc_pkg::IN_W-1:0]  in_frequency,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mhc_pkg::OUT_W-1:0] out_capacity_ratio
);

  logic                        en;
  logic                        f0_vld_r, f0_zero_r;
  logic [mhc_pkg::NUM_W-1:0]   f0_num_r;
  logic [mhc_pkg::DEN_W-1:0]   f0_den_r;

  logic                        dv_vld_r  [0:mhc_pkg::X_W];
  logic                        dv_zero_r [0:mhc_pkg::X_W];
  logic                        dv_ovf_r  [0:mhc_pkg::X_W];
  logic [mhc_pkg::NUM_W-1:0]   dv_rem_r  [0:mhc_pkg::X_W];
  logic [mhc_pkg::DEN_W-1:0]   dv_den_r  [0:mhc_pkg::X_W];
  logic [mhc_pkg::X_W-1:0]     dv_q_r    [0:mhc_pkg::X_W];

  mhc_pkg::item_t              x_item, ed_item;
  logic [63:0]                 ed_e, ed_d;

  // every stage moves together unless the output holds a result nobody takes
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (en) begin
      f0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_num_r  <= mhc_pkg::NUM_W'(in_frequency) * mhc_pkg::NUM_W'(mhc_pkg::KX_Q32);
      f0_den_r  <= {in_temperature, {mhc_pkg::DEN_SHIFT{1'b0}}};
      f0_zero_r <= (in_temperature == '0) || (in_frequency == '0);
    end
  end

  // x >= 32 shows up as num >= den * 2^29
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= f0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= f0_num_r;
      dv_den_r[0]  <= f0_den_r;
      dv_zero_r[0] <= f0_zero_r;
      dv_ovf_r[0]  <= mhc_pkg::CMP_W'(f0_num_r) >= {f0_den_r, {mhc_pkg::X_W{1'b0}}};
      dv_q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < mhc_pkg::X_W; k++) begin : g_xdiv
    localparam int B = mhc_pkg::X_W - 1 - k;
    logic [mhc_pkg::CMP_W-1:0] dsh_nxt, diff_nxt;
    logic                      ge_nxt;

    always_comb begin
      dsh_nxt  = mhc_pkg::CMP_W'(dv_den_r[k]) << B;
      ge_nxt   = mhc_pkg::CMP_W'(dv_rem_r[k]) >= dsh_nxt;
      diff_nxt = mhc_pkg::CMP_W'(dv_rem_r[k]) - dsh_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1]  <= ge_nxt ? diff_nxt[mhc_pkg::NUM_W-1:0] : dv_rem_r[k];
        dv_q_r[k+1]    <= {dv_q_r[k][mhc_pkg::X_W-2:0], ge_nxt};
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_ovf_r[k+1]  <= dv_ovf_r[k];
      end
    end
  end

  always_comb begin
    x_item.vld = dv_vld_r[mhc_pkg::X_W];
    x_item.x   = dv_q_r[mhc_pkg::X_W];
    if (dv_zero_r[mhc_pkg::X_W] || dv_ovf_r[mhc_pkg::X_W]) begin
      x_item.sel = mhc_pkg::SEL_ZERO;
    end else if (dv_q_r[mhc_pkg::X_W] == '0) begin
      x_item.sel = mhc_pkg::SEL_ONE;
    end else begin
      x_item.sel = mhc_pkg::SEL_CALC;
    end
  end

  mhc_expo u_expo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_item  (x_item),
    .out_item (ed_item),
    .e_out    (ed_e),
    .d_out    (ed_d)
  );

  mhc_qdiv u_qdiv (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .in_item            (ed_item),
    .in_e               (ed_e),
    .in_d               (ed_d),
    .out_valid          (out_valid),
    .out_capacity_ratio (out_capacity_ratio)
  );

endmodule

/* hw/rtl/mhc_checker.sv */
`timescale 1ns / 1ps
module mhc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [mhc_pkg::IN_W-1:0]  in_temperature,
  input logic [mhc_pkg::IN_W-1:0]  in_frequency,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mhc_pkg::OUT_W-1:0] out_capacity_ratio
);

  // result is a fraction of one
  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_capacity_ratio <= mhc_pkg::OUT_ONE)
    else $error("capacity ratio above one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_capacity_ratio))
    else $error("stalled result changed");

  // an empty output stage never blocks an input transfer
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind mode_heat_capacity mhc_checker u_mhc_checker (.*);

/* tb/mode_heat_capacity_tb.sv */
`timescale 1ns / 1ps
module mode_heat_capacity_tb;

  localparam int LATENCY    = 167;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 580;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [mhc_pkg::IN_W-1:0]  in_temperature;
  logic [mhc_pkg::IN_W-1:0]  in_frequency;
  logic                      out_valid;
  logic                      out_ready;
  logic [mhc_pkg::OUT_W-1:0] out_capacity_ratio;

  logic [mhc_pkg::OUT_W-1:0] ratio_q[$];
  int                        n_accepted;
  int                        n_errors;
  int                        idle_cycles;
  bit                        gaps_on;

  mode_heat_capacity i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_temperature     (in_temperature),
    .in_frequency       (in_frequency),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_capacity_ratio (out_capacity_ratio)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^s), low 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic logic [mhc_pkg::OUT_W-1:0] heat_capacity_ratio(
    logic [mhc_pkg::IN_W-1:0] temp,
    logic [mhc_pkg::IN_W-1:0] freq);
    logic [63:0]  num, den, x, r, t, d, e, q, q2;
    logic [129:0] acc;
    logic [127:0] dividend;
    if (temp == 0 || freq == 0) return '0;
    num = 64'(freq) * 64'(mhc_pkg::KX_Q32);
    den = 64'(temp) << 6;
    x = num / den;
    if (x >= (64'd32 << 24)) return '0;
    if (x == 0) return mhc_pkg::OUT_ONE;
    r = x << 31;
    t = r;
    d = r;
    for (int n = 2; n <= 16; n++) begin
      t = mul_shr(t, r, 62) / n;
      if (n % 2 == 1) d = d + t;
      else d = d - t;
    end
    e = mhc_pkg::ONE_Q62 - d;
    for (int k = 0; k < 7; k++) begin
      e = mul_shr(e, e, 62);
      d = mul_shr(d, mhc_pkg::TWO_Q62 - d, 62);
    end
    dividend = {64'd0, x} << 70;
    if (d == 0) q = '1;
    else q = 64'(dividend / {64'd0, d});
    q2 = mul_shr(q, q, 32);
    acc = ({66'd0, q2} * {66'd0, e}) + (130'd1 << (93 - mhc_pkg::OUT_FRAC));
    acc = acc >> (94 - mhc_pkg::OUT_FRAC);
    if (acc[129:64] != 0 || acc[63:0] > 64'(mhc_pkg::OUT_ONE)) return mhc_pkg::OUT_ONE;
    return mhc_pkg::OUT_W'(acc);
  endfunction

  // transfer bookkeeping and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        ratio_q.push_back(heat_capacity_ratio(in_temperature, in_frequency));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (ratio_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_capacity_ratio);
          n_errors <= n_errors + 1;
        end else begin
          if (ratio_q[0] !== out_capacity_ratio) begin
            $display("%0t: capacity_ratio mismatch, expected %0d, actual %0d",
                     $time, ratio_q[0], out_capacity_ratio);
            n_errors <= n_errors + 1;
          end
          void'(ratio_q.pop_front());
        end
      end
    end
  end

  // receiver back-pressure, long stalls now and then
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (!gaps_on) begin
      out_ready <= 1'b1;
    end else begin
      stall = $urandom_range(0, 99);
      if (stall < 70) out_ready <= 1'b1;
      else if (stall < 97) out_ready <= 1'b0;
      else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[mode_heat_capacity] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic [mhc_pkg::IN_W-1:0] temp, logic [mhc_pkg::IN_W-1:0] freq);
    int gap;
    int target;
    gap = 0;
    if (gaps_on) begin
      gap = $urandom_range(0, 99);
      if (gap < 60) gap = 0;
      else if (gap < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    target = n_accepted + 1;
    in_valid       <= 1'b1;
    in_temperature <= temp;
    in_frequency   <= freq;
    @(posedge clk);
    wait (n_accepted == target);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (ratio_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [mhc_pkg::IN_W-1:0] max_v;
    max_v = '1;
    send_item('0, '0);
    send_item('0, max_v);
    send_item(max_v, '0);
    send_item(max_v, max_v);
    send_item(20'd1, 20'd1);
    send_item(max_v, 20'd1);
    send_item(20'd1, max_v);
    send_item(20'd1000, 20'd5700);
    send_item(20'd1000, 20'd5500);
    send_item(20'd100000, 20'd1);
    send_item(20'd100000, 20'd100);
    send_item(20'd100000, 20'd100000);
    send_item(20'h55555, 20'haaaaa);
    send_item(20'haaaaa, 20'h55555);
    send_item(20'd76800, 20'd64000);
    send_item(20'd256, 20'd64);
    send_item(max_v, 20'd2);
  endtask

  task automatic test_random(int count);
    logic [mhc_pkg::IN_W-1:0]  temp, freq;
    logic [mhc_pkg::IN_W+12:0] scaled;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        temp = mhc_pkg::IN_W'($urandom);
        freq = mhc_pkg::IN_W'($urandom);
      end else begin
        // keep freq/temp mostly below the flush ratio so the curve is exercised
        temp = mhc_pkg::IN_W'($urandom_range(1, (1 << mhc_pkg::IN_W) - 1));
        scaled = ((mhc_pkg::IN_W+13)'(temp) * $urandom_range(1, 6000)) >> 10;
        freq = (scaled == 0) ? mhc_pkg::IN_W'(1) :
               (scaled > (mhc_pkg::IN_W+13)'((1 << mhc_pkg::IN_W) - 1)) ? '1 :
               mhc_pkg::IN_W'(scaled);
      end
      send_item(temp, freq);
      if (i == count / 2) gaps_on = ~gaps_on;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_temperature = '0;
    in_frequency   = '0;
    n_accepted     = 0;
    n_errors       = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    gaps_on = 1'b1;
    test_random(N_RANDOM / 2);
    wait_drained();
    test_random(N_RANDOM / 2);
    wait_drained();
    if (n_errors == 0) begin
      $display("[mode_heat_capacity] OK");
    end else begin
      $display("[mode_heat_capacity] ERROR");
    end
    $finish;
  end

endmodule
